>>> hw/rtl/cct_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the cubic curve tessellator.
// Used by cct_ctrl, cct_datapath and the top level; depends on nothing.
package cct_pkg;

   localparam int MAX_SAMPLES = 16;
   localparam int SAMP_W      = 5;
   localparam int CNT_W       = 16;
   localparam int COORD_W     = 32;
   localparam int WGT_W       = 17;
   localparam int ACC_W       = 52;
   localparam int QUO_BITS    = 34;
   localparam int DEN_W       = 15;
   localparam int REM_W       = 16;
   localparam int CSR_DATA_W  = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int DCNT_W      = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_BASIS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIODIC = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 2'd3;

   typedef enum logic [1:0] {
      BASIS_LINEAR   = 2'd0,
      BASIS_BSPLINE  = 2'd1,
      BASIS_CATMULL  = 2'd2,
      BASIS_BEZIER   = 2'd3
   } basis_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WGT,
      ST_MAC,
      ST_PREP,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      IK_NONE,
      IK_ERR,
      IK_PASS,
      IK_CUBIC
   } item_kind_type;

   typedef enum logic [1:0] {
      OUT_SAMPLE,
      OUT_PASS,
      OUT_ERR
   } out_sel_type;

   typedef logic signed [WGT_W-1:0] wgt_type;
   typedef wgt_type [3:0] wgt_set_type;

   typedef struct packed {
      logic              take;
      logic              wgt_load;
      logic              mac_en;
      logic [1:0]        mac_j;
      logic [1:0]        seg_o;
      logic [SAMP_W-1:0] k;
      logic              div_init;
      logic              div_step;
      logic              out_load;
      out_sel_type       out_sel;
      logic              out_curve_end;
      logic              out_run_last;
   } dp_cmd_type;

   typedef struct packed {
      item_kind_type     kind;
      logic [3:0]        seg_mask;
      logic              close;
      logic              last;
      logic [SAMP_W-1:0] s;
   } dp_status_type;

   // Residue modulo 3 of a 16-bit count; base-4 digits each weigh 1 modulo 3.
   function automatic logic [1:0] mod3_16(input logic [CNT_W-1:0] v);
      logic [4:0] sum;
      logic [2:0] sum2;
      logic [1:0] res;
      sum = '0;
      for (int d = 0; d < 8; d++) begin
         sum = sum + 5'(v[2*d +: 2]);
      end
      sum2 = 3'(sum[1:0]) + 3'(sum[3:2]) + 3'(sum[4]);
      if (sum2 >= 3'd6) begin
         res = 2'(sum2 - 3'd6);
      end else if (sum2 >= 3'd3) begin
         res = 2'(sum2 - 3'd3);
      end else begin
         res = sum2[1:0];
      end
      return res;
   endfunction

   // Common denominator 6*S^3 of all basis weights.
   function automatic logic [DEN_W-1:0] den(input logic [SAMP_W-1:0] s);
      logic [14:0] s3;
      s3 = 15'(s) * 15'(s) * 15'(s);
      return DEN_W'(s3 * 15'd6);
   endfunction

   // Integer basis weights of sample k out of s, all over 6*s^3.
   function automatic wgt_set_type weights(input basis_type b, input logic [SAMP_W-1:0] k,
                                           input logic [SAMP_W-1:0] s);
      logic signed [19:0] kk, ss, u, k2, k3, s2, s3, c0, c1, c2, c3;
      wgt_set_type r;
      kk = signed'(20'(k));
      ss = signed'(20'(s));
      u  = ss - kk;
      k2 = kk * kk;
      k3 = k2 * kk;
      s2 = ss * ss;
      s3 = s2 * ss;
      unique case (b)
         BASIS_BSPLINE: begin
            c0 = u * u * u;
            c1 = 20'(3 * k3) - 20'(6 * k2 * ss) + 20'(4 * s3);
            c2 = 20'(-3 * k3) + 20'(3 * k2 * ss) + 20'(3 * kk * s2) + s3;
            c3 = k3;
         end
         BASIS_CATMULL: begin
            c0 = 20'(3 * (-k3 + 20'(2 * k2 * ss) - kk * s2));
            c1 = 20'(3 * (20'(3 * k3) - 20'(5 * k2 * ss) + 20'(2 * s3)));
            c2 = 20'(3 * (20'(-3 * k3) + 20'(4 * k2 * ss) + kk * s2));
            c3 = 20'(3 * (k3 - k2 * ss));
         end
         default: begin
            c0 = 20'(6 * u * u * u);
            c1 = 20'(18 * kk * u * u);
            c2 = 20'(18 * k2 * u);
            c3 = 20'(6 * k3);
         end
      endcase
      r[0] = WGT_W'(c0);
      r[1] = WGT_W'(c1);
      r[2] = WGT_W'(c2);
      r[3] = WGT_W'(c3);
      return r;
   endfunction

endpackage

>>> hw/rtl/cct_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the cubic curve tessellator: item plan, segment and sample walk.
// Depends on cct_pkg; drives the datapath through dp_cmd_type.
module cct_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  cct_pkg::dp_status_type status_i,
   output cct_pkg::dp_cmd_type   cmd_o
);

   cct_pkg::state_type             state_ff, state_in;
   cct_pkg::item_kind_type         kind_ff, kind_in;
   logic [3:0]                     mask_ff, mask_in;
   logic                           close_ff, close_in;
   logic                           last_ff, last_in;
   logic [1:0]                     o_ff, o_in;
   logic [cct_pkg::SAMP_W-1:0]     k_ff, k_in;
   logic [1:0]                     j_ff, j_in;
   logic [cct_pkg::DCNT_W-1:0]     dcnt_ff, dcnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [cct_pkg::SAMP_W-1:0]     kmax;
   logic [3:0]                     mask_rem;

   function automatic logic [1:0] lsb4(input logic [3:0] m);
      logic [1:0] r;
      priority if (m[0]) r = 2'd0;
      else if (m[1])     r = 2'd1;
      else if (m[2])     r = 2'd2;
      else               r = 2'd3;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cct_pkg::ST_IDLE;
         kind_ff      <= cct_pkg::IK_NONE;
         mask_ff      <= '0;
         close_ff     <= 1'b0;
         last_ff      <= 1'b0;
         o_ff         <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         mask_ff      <= mask_in;
         close_ff     <= close_in;
         last_ff      <= last_in;
         o_ff         <= o_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      mask_in   = mask_ff;
      close_in  = close_ff;
      last_in   = last_ff;
      o_in      = o_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      dcnt_in   = dcnt_ff;
      req_ready = 1'b0;
      cmd_o     = '0;
      cmd_o.mac_j = j_ff;
      cmd_o.seg_o = o_ff;
      cmd_o.k     = k_ff;
      // The closing sample only belongs to the ordinary segment of a curve's last point.
      kmax      = (close_ff && (o_ff == 2'd0)) ? status_i.s : status_i.s - 5'd1;
      mask_rem  = mask_ff & ~(4'b0001 << o_ff);

      unique case (state_ff)
         cct_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.take = 1'b1;
               kind_in  = status_i.kind;
               mask_in  = status_i.seg_mask;
               close_in = status_i.close;
               last_in  = status_i.last;
               o_in     = lsb4(status_i.seg_mask);
               k_in     = '0;
               if (status_i.kind == cct_pkg::IK_ERR || status_i.kind == cct_pkg::IK_PASS) begin
                  state_in = cct_pkg::ST_OUT;
               end else if (status_i.kind == cct_pkg::IK_CUBIC && status_i.seg_mask != 4'd0) begin
                  state_in = cct_pkg::ST_WGT;
               end
            end
         end
         cct_pkg::ST_WGT: begin
            cmd_o.wgt_load = 1'b1;
            j_in     = '0;
            state_in = cct_pkg::ST_MAC;
         end
         cct_pkg::ST_MAC: begin
            cmd_o.mac_en = 1'b1;
            j_in = j_ff + 2'd1;
            if (j_ff == 2'd3) begin
               state_in = cct_pkg::ST_PREP;
            end
         end
         cct_pkg::ST_PREP: begin
            cmd_o.div_init = 1'b1;
            dcnt_in  = '0;
            state_in = cct_pkg::ST_DIV;
         end
         cct_pkg::ST_DIV: begin
            cmd_o.div_step = 1'b1;
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'(cct_pkg::QUO_BITS - 1)) begin
               state_in = cct_pkg::ST_OUT;
            end
         end
         cct_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd_o.out_load = 1'b1;
               if (kind_ff != cct_pkg::IK_CUBIC) begin
                  cmd_o.out_sel = (kind_ff == cct_pkg::IK_ERR) ? cct_pkg::OUT_ERR
                                                               : cct_pkg::OUT_PASS;
                  cmd_o.out_run_last  = 1'b1;
                  cmd_o.out_curve_end = (kind_ff == cct_pkg::IK_PASS) && last_ff;
                  state_in = cct_pkg::ST_IDLE;
               end else begin
                  cmd_o.out_sel = cct_pkg::OUT_SAMPLE;
                  state_in = cct_pkg::ST_WGT;
                  if (k_ff == kmax) begin
                     k_in    = '0;
                     mask_in = mask_rem;
                     o_in    = lsb4(mask_rem);
                     if (mask_rem == 4'd0) begin
                        cmd_o.out_run_last  = 1'b1;
                        cmd_o.out_curve_end = last_ff;
                        state_in = cct_pkg::ST_IDLE;
                     end
                  end else begin
                     k_in = k_ff + 5'd1;
                  end
               end
            end
         end
         default: begin
            state_in = cct_pkg::ST_IDLE;
         end
      endcase

      if (cmd_o.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/cct_datapath.sv
`timescale 1ns / 1ps
// Datapath of the cubic curve tessellator: registers, point window, curve head,
// weight MAC, four-lane restoring divider and result register. Depends on cct_pkg.
module cct_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [cct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cct_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic signed [31:0]             req_pos_x,
   input  logic signed [31:0]             req_pos_y,
   input  logic signed [31:0]             req_pos_z,
   input  logic signed [31:0]             req_point_width,
   input  logic [15:0]                    req_curve_vertices,
   input  logic                           req_batch_start,
   input  cct_pkg::dp_cmd_type            cmd_i,
   output cct_pkg::dp_status_type         status_o,
   output logic signed [31:0]             rsp_out_x,
   output logic signed [31:0]             rsp_out_y,
   output logic signed [31:0]             rsp_out_z,
   output logic [30:0]                    rsp_out_width,
   output logic                           rsp_curve_end,
   output logic                           rsp_run_last,
   output logic                           rsp_status
);

   cct_pkg::basis_type          basis_ff;
   logic                        periodic_ff;
   logic [4:0]                  spp_ff;
   logic                        wpp_ff;

   logic signed [31:0]          win_ff [4][4];
   logic signed [31:0]          head_ff [3][4];
   logic [15:0]                 ps_ff, ps_in;
   logic [1:0]                  ph_ff, ph_in;
   logic [15:0]                 len_ff, len_in;
   logic [1:0]                  lm3_ff, lm3_in;
   logic                        err_ff, err_in;

   cct_pkg::wgt_set_type        c_ff;
   logic signed [cct_pkg::ACC_W-1:0] acc_ff [4];
   logic                        neg_ff [4];
   logic [cct_pkg::REM_W-1:0]   rem_ff [4];
   logic [cct_pkg::QUO_BITS-1:0] qr_ff [4];

   logic signed [31:0]          ox_ff, oy_ff, oz_ff;
   logic [30:0]                 ow_ff;
   logic                        oce_ff, orl_ff, ost_ff;

   logic [4:0]                  s_val;
   logic [cct_pkg::DEN_W-1:0]   d_val;
   logic signed [31:0]          pin [4];
   logic                        err_eff, first, bad, point_ok, last;
   logic [15:0]                 i_eff, cnt_eff;
   logic [1:0]                  m3_in, m3_eff, ph_eff;
   logic [3:0]                  mask;
   logic                        step1;
   logic [2:0]                  idx;
   logic [2:0]                  hidx;
   logic signed [31:0]          pt [4];
   logic signed [31:0]          vsat [4];

   assign s_val = (spp_ff == 5'd0) ? 5'd1 :
                  (spp_ff > 5'(cct_pkg::MAX_SAMPLES)) ? 5'(cct_pkg::MAX_SAMPLES) : spp_ff;
   assign d_val = cct_pkg::den(s_val);

   assign pin[0] = req_pos_x;
   assign pin[1] = req_pos_y;
   assign pin[2] = req_pos_z;
   assign pin[3] = req_point_width;

   // Decision for the offered point, taken from the state before it is applied.
   always_comb begin
      step1   = (basis_ff != cct_pkg::BASIS_BEZIER);
      err_eff = req_batch_start ? 1'b0 : err_ff;
      i_eff   = req_batch_start ? 16'd0 : ps_ff;
      ph_eff  = req_batch_start ? 2'd0 : ph_ff;
      first   = (i_eff == 16'd0);
      m3_in   = cct_pkg::mod3_16(req_curve_vertices);
      if (basis_ff == cct_pkg::BASIS_LINEAR) begin
         bad = (req_curve_vertices == 16'd0);
      end else if (req_curve_vertices < 16'd4) begin
         bad = 1'b1;
      end else if (step1) begin
         bad = 1'b0;
      end else if (periodic_ff) begin
         bad = (m3_in != 2'd0);
      end else begin
         bad = (m3_in != 2'd1);
      end
      cnt_eff  = first ? req_curve_vertices : len_ff;
      m3_eff   = first ? m3_in : lm3_ff;
      point_ok = !err_eff && !(first && bad);
      last     = ({1'b0, i_eff} + 17'd1) >= {1'b0, cnt_eff};
      mask[0]  = (i_eff >= 16'd3) && (step1 || ph_eff == 2'd0);
      // Wrapping segment o starts at cnt-4+o, which is cnt+o-1 modulo 3.
      mask[1]  = periodic_ff && last && (step1 || m3_eff == 2'd0);
      mask[2]  = periodic_ff && last && (step1 || m3_eff == 2'd2);
      mask[3]  = periodic_ff && last && (step1 || m3_eff == 2'd1);

      status_o.s        = s_val;
      status_o.seg_mask = mask;
      status_o.close    = !periodic_ff && last;
      status_o.last     = last;
      if (err_eff) begin
         status_o.kind = cct_pkg::IK_NONE;
      end else if (first && bad) begin
         status_o.kind = cct_pkg::IK_ERR;
      end else if (basis_ff == cct_pkg::BASIS_LINEAR) begin
         status_o.kind = cct_pkg::IK_PASS;
      end else if (cnt_eff >= 16'd4) begin
         status_o.kind = cct_pkg::IK_CUBIC;
      end else begin
         status_o.kind = cct_pkg::IK_NONE;
      end

      err_in = err_ff;
      ps_in  = ps_ff;
      ph_in  = ph_ff;
      len_in = len_ff;
      lm3_in = lm3_ff;
      if (cmd_i.take) begin
         err_in = err_eff;
         ps_in  = i_eff;
         ph_in  = ph_eff;
         if (!err_eff && first && bad) begin
            err_in = 1'b1;
            ps_in  = 16'd0;
            ph_in  = 2'd0;
         end else if (point_ok) begin
            if (first) begin
               len_in = req_curve_vertices;
               lm3_in = m3_in;
            end
            ps_in = last ? 16'd0 : i_eff + 16'd1;
            ph_in = last ? 2'd0 : ((ph_eff == 2'd2) ? 2'd0 : ph_eff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         basis_ff    <= cct_pkg::BASIS_BSPLINE;
         periodic_ff <= 1'b0;
         spp_ff      <= 5'd1;
         wpp_ff      <= 1'b0;
         ps_ff       <= '0;
         ph_ff       <= '0;
         len_ff      <= '0;
         lm3_ff      <= '0;
         err_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               cct_pkg::CSR_BASIS:    basis_ff    <= cct_pkg::basis_type'(csr_wdata[1:0]);
               cct_pkg::CSR_PERIODIC: periodic_ff <= csr_wdata[0];
               cct_pkg::CSR_SAMPLES:  spp_ff      <= csr_wdata;
               cct_pkg::CSR_WIDTH:    wpp_ff      <= csr_wdata[0];
               default: ;
            endcase
         end
         ps_ff  <= ps_in;
         ph_ff  <= ph_in;
         len_ff <= len_in;
         lm3_ff <= lm3_in;
         err_ff <= err_in;
      end
   end

   // Window of the last four points, oldest first, and the curve's first three points.
   always_ff @(posedge clock) begin
      if (cmd_i.take && point_ok) begin
         for (int f = 0; f < 4; f++) begin
            win_ff[0][f] <= win_ff[1][f];
            win_ff[1][f] <= win_ff[2][f];
            win_ff[2][f] <= win_ff[3][f];
            win_ff[3][f] <= pin[f];
         end
         if (i_eff < 16'd3) begin
            for (int f = 0; f < 4; f++) begin
               head_ff[i_eff[1:0]][f] <= pin[f];
            end
         end
      end
   end

   // Segment o uses points o..o+3 of the window followed by the head.
   always_comb begin
      idx  = {1'b0, cmd_i.seg_o} + {1'b0, cmd_i.mac_j};
      hidx = idx - 3'd4;
      for (int f = 0; f < 4; f++) begin
         pt[f] = (idx < 3'd4) ? win_ff[idx[1:0]][f] : head_ff[hidx[1:0]][f];
      end
   end

   always_ff @(posedge clock) begin
      logic signed [cct_pkg::ACC_W-1:0] n;
      logic [cct_pkg::ACC_W-1:0]        m;
      logic [cct_pkg::REM_W-1:0]        t;
      logic                             ge;
      logic signed [cct_pkg::WGT_W+cct_pkg::COORD_W-1:0] prod;
      if (cmd_i.wgt_load) begin
         c_ff <= cct_pkg::weights(basis_ff, cmd_i.k, s_val);
      end
      for (int f = 0; f < 4; f++) begin
         n    = '0;
         m    = '0;
         t    = '0;
         ge   = 1'b0;
         prod = '0;
         if (cmd_i.wgt_load) begin
            acc_ff[f] <= '0;
         end else if (cmd_i.mac_en) begin
            prod = c_ff[cmd_i.mac_j] * pt[f];
            acc_ff[f] <= acc_ff[f] + cct_pkg::ACC_W'(prod);
         end
         if (cmd_i.div_init) begin
            n = acc_ff[f] + signed'(cct_pkg::ACC_W'(d_val >> 1));
            m = n[cct_pkg::ACC_W-1] ? cct_pkg::ACC_W'(-n) : cct_pkg::ACC_W'(n);
            neg_ff[f] <= n[cct_pkg::ACC_W-1];
            rem_ff[f] <= cct_pkg::REM_W'(m >> cct_pkg::QUO_BITS);
            qr_ff[f]  <= m[cct_pkg::QUO_BITS-1:0];
         end else if (cmd_i.div_step) begin
            t  = {rem_ff[f][cct_pkg::REM_W-2:0], qr_ff[f][cct_pkg::QUO_BITS-1]};
            ge = (t >= cct_pkg::REM_W'(d_val));
            rem_ff[f] <= ge ? t - cct_pkg::REM_W'(d_val) : t;
            qr_ff[f]  <= {qr_ff[f][cct_pkg::QUO_BITS-2:0], ge};
         end
      end
   end

   // Floor of the signed quotient, then saturation to 32 bits.
   always_comb begin
      logic signed [35:0] q;
      logic signed [35:0] v;
      for (int f = 0; f < 4; f++) begin
         q = signed'({2'b00, qr_ff[f]});
         if (neg_ff[f]) begin
            v = -(q + ((rem_ff[f] != '0) ? 36'sd1 : 36'sd0));
         end else begin
            v = q;
         end
         if (v > 36'sd2147483647) begin
            vsat[f] = 32'sh7FFFFFFF;
         end else if (v < -36'sd2147483648) begin
            vsat[f] = 32'sh80000000;
         end else begin
            vsat[f] = 32'(v);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.out_load) begin
         oce_ff <= cmd_i.out_curve_end;
         orl_ff <= cmd_i.out_run_last;
         unique case (cmd_i.out_sel)
            cct_pkg::OUT_SAMPLE: begin
               ox_ff  <= vsat[0];
               oy_ff  <= vsat[1];
               oz_ff  <= vsat[2];
               ow_ff  <= (!wpp_ff || vsat[3][31]) ? 31'd0 : vsat[3][30:0];
               ost_ff <= 1'b0;
            end
            cct_pkg::OUT_PASS: begin
               ox_ff  <= win_ff[3][0];
               oy_ff  <= win_ff[3][1];
               oz_ff  <= win_ff[3][2];
               ow_ff  <= (!wpp_ff || win_ff[3][3][31]) ? 31'd0 : win_ff[3][3][30:0];
               ost_ff <= 1'b0;
            end
            default: begin
               ox_ff  <= '0;
               oy_ff  <= '0;
               oz_ff  <= '0;
               ow_ff  <= '0;
               ost_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_out_x     = ox_ff;
   assign rsp_out_y     = oy_ff;
   assign rsp_out_z     = oz_ff;
   assign rsp_out_width = ow_ff;
   assign rsp_curve_end = oce_ff;
   assign rsp_run_last  = orl_ff;
   assign rsp_status    = ost_ff;

endmodule

>>> hw/rtl/cubic_curve_tessellator.sv
`timescale 1ns / 1ps
// Top level of the cubic curve tessellator: sequencer plus datapath.
// Depends on cct_pkg, cct_ctrl and cct_datapath.
//
//   channel  direction  signals
//   req      in         req_valid/req_ready, pos_x/y/z, point_width, curve_vertices,
//                       batch_start
//   rsp      out        rsp_valid/rsp_ready, out_x/y/z, out_width, curve_end,
//                       run_last, status
//   csr      in         csr_wr_en, csr_index, csr_wdata (write only)
//
// A point is taken in the idle state; each cubic sample then passes through the weight
// load, the weight MAC over the four points, rounding, the restoring divider and the
// load of the result register. Pass-through and error beats go from the idle state
// straight to the result register load. Up to four segments per point.
// Reset is synchronous and needs no clearing pass. A stalled rsp beat holds the
// sequencer only when the next result is ready; new points wait for the idle state.
module cubic_curve_tessellator (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [4:0]         csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_point_width,
   input  logic [15:0]        req_curve_vertices,
   input  logic               req_batch_start,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic [30:0]        rsp_out_width,
   output logic               rsp_curve_end,
   output logic               rsp_run_last,
   output logic               rsp_status
);

   cct_pkg::dp_cmd_type    cmd;
   cct_pkg::dp_status_type status;

   cct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   cct_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_point_width    (req_point_width),
      .req_curve_vertices (req_curve_vertices),
      .req_batch_start    (req_batch_start),
      .cmd_i              (cmd),
      .status_o           (status),
      .rsp_out_x          (rsp_out_x),
      .rsp_out_y          (rsp_out_y),
      .rsp_out_z          (rsp_out_z),
      .rsp_out_width      (rsp_out_width),
      .rsp_curve_end      (rsp_curve_end),
      .rsp_run_last       (rsp_run_last),
      .rsp_status         (rsp_status)
   );

endmodule

>>> dv/tb_cubic_curve_tessellator.sv
`timescale 1ns / 1ps
// Self-checking testbench of cubic_curve_tessellator: directed curves for each basis,
// then random curve streams with random sender gaps and receiver stalls.
// Depends on cct_pkg and the cubic_curve_tessellator RTL.
module tb_cubic_curve_tessellator;

   localparam int  CYCLE_LIMIT = 10000000;
   localparam int  SETTLE      = 200;

   typedef struct {
      logic signed [31:0] x, y, z;
      logic [30:0]        w;
      logic               ce, rl, st;
   } curve_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [4:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0, req_point_width = '0;
   logic [15:0] req_curve_vertices = '0;
   logic req_batch_start = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [30:0] rsp_out_width;
   logic rsp_curve_end, rsp_run_last, rsp_status;

   cubic_curve_tessellator dut (.*);

   always #10 clock = ~clock;

   // Shadow of the block's registers and curve state.
   cct_pkg::basis_type cfg_basis = cct_pkg::BASIS_BSPLINE;
   logic               cfg_periodic = 1'b0;
   logic [4:0]         cfg_samples = 5'd1;
   logic               cfg_wpp = 1'b0;
   logic signed [31:0] win_pts[16];
   logic signed [31:0] head_pts[12];
   int                 pos_in_curve = 0;
   int                 cur_len = 0;
   bit                 err_latched = 0;

   curve_sample_type expected_samples[$];
   curve_sample_type step_samples[$];
   int  errors = 0;
   int  cycles = 0;
   int  burst_left = 0;
   int  taken_points = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d samples outstanding", expected_samples.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver stall pattern: a randomly redrawn mode picks one of four ready patterns.
   int stall_mode = 0;
   always @(posedge clock) begin
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) != 0);
         default: rsp_ready <= (cycles % 11 < 3);
      endcase
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   always @(posedge clock) begin
      curve_sample_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            e = expected_samples.pop_front();
            if (rsp_out_x !== e.x) report_mismatch("out_x", rsp_out_x, e.x);
            if (rsp_out_y !== e.y) report_mismatch("out_y", rsp_out_y, e.y);
            if (rsp_out_z !== e.z) report_mismatch("out_z", rsp_out_z, e.z);
            if (rsp_out_width !== e.w) report_mismatch("out_width", rsp_out_width, e.w);
            if (rsp_curve_end !== e.ce) report_mismatch("curve_end", rsp_curve_end, e.ce);
            if (rsp_run_last !== e.rl) report_mismatch("run_last", rsp_run_last, e.rl);
            if (rsp_status !== e.st) report_mismatch("status", rsp_status, e.st);
         end
      end
   end

   function automatic longint floor_div(input longint n, input longint d);
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic void push_sample(input longint x, y, z, w, input logic st);
      curve_sample_type r;
      r.x = x[31:0]; r.y = y[31:0]; r.z = z[31:0]; r.w = w[30:0];
      r.ce = 1'b0; r.rl = 1'b0; r.st = st;
      step_samples = {step_samples, r};
   endfunction

   function automatic void basis_weights(input longint k, s, output longint c[4]);
      longint k2, k3, s2, s3, u;
      k2 = k * k; k3 = k2 * k; s2 = s * s; s3 = s2 * s; u = s - k;
      case (cfg_basis)
         cct_pkg::BASIS_BSPLINE: begin
            c[0] = u * u * u;
            c[1] = 3 * k3 - 6 * k2 * s + 4 * s3;
            c[2] = -3 * k3 + 3 * k2 * s + 3 * k * s2 + s3;
            c[3] = k3;
         end
         cct_pkg::BASIS_CATMULL: begin
            c[0] = 3 * (-k3 + 2 * k2 * s - k * s2);
            c[1] = 3 * (3 * k3 - 5 * k2 * s + 2 * s3);
            c[2] = 3 * (-3 * k3 + 4 * k2 * s + k * s2);
            c[3] = 3 * (k3 - k2 * s);
         end
         default: begin
            c[0] = 6 * u * u * u;
            c[1] = 18 * k * u * u;
            c[2] = 18 * k2 * u;
            c[3] = 6 * k3;
         end
      endcase
   endfunction

   function automatic void sample_segment(input logic signed [31:0] pts[16],
                                          input longint s, kmax);
      longint d, acc, c[4], v[4];
      d = 6 * s * s * s;
      for (longint k = 0; k <= kmax; k++) begin
         basis_weights(k, s, c);
         for (int f = 0; f < 4; f++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) acc += c[j] * longint'(pts[j*4+f]);
            v[f] = sat32(floor_div(acc + d / 2, d));
         end
         if (!cfg_wpp || v[3] < 0) v[3] = 0;
         push_sample(v[0], v[1], v[2], v[3], 1'b0);
      end
   endfunction

   // Updates the curve state for one accepted point and queues its samples.
   // Returns 0 when the point is dropped under a latched error.
   function automatic bit tessellate_point(input logic signed [31:0] px, py, pz, pw,
                                           input logic [15:0] vcount, input logic bstart);
      int  stp, idx, cnt, m;
      longint s, kmax, w;
      bit  bad, last;
      logic signed [31:0] p[4];
      logic signed [31:0] wrap[16];
      step_samples.delete();
      stp = (cfg_basis == cct_pkg::BASIS_BEZIER) ? 3 : 1;
      s = (cfg_samples < 1) ? 1 : (cfg_samples > cct_pkg::MAX_SAMPLES ? cct_pkg::MAX_SAMPLES
                                                                       : cfg_samples);
      if (bstart) begin
         err_latched = 0;
         pos_in_curve = 0;
      end
      if (err_latched) return 0;
      p[0] = px; p[1] = py; p[2] = pz; p[3] = pw;
      if (pos_in_curve == 0) begin
         cnt = vcount;
         if (cfg_basis == cct_pkg::BASIS_LINEAR) bad = (cnt == 0);
         else if (cnt < 4) bad = 1;
         else if (cfg_periodic) bad = (cnt % stp) != 0;
         else bad = ((cnt - 4) % stp) != 0;
         if (bad) begin
            err_latched = 1;
            push_sample(0, 0, 0, 0, 1'b1);
            step_samples[0].rl = 1'b1;
            expected_samples = {expected_samples, step_samples};
            return 1;
         end
         cur_len = cnt;
      end
      idx = pos_in_curve;
      cnt = cur_len;
      for (int q = 0; q < 12; q++) win_pts[q] = win_pts[q+4];
      for (int f = 0; f < 4; f++) win_pts[12+f] = p[f];
      if (idx < 3) for (int f = 0; f < 4; f++) head_pts[idx*4+f] = p[f];
      last = (idx + 1 >= cnt);
      if (cfg_basis == cct_pkg::BASIS_LINEAR) begin
         w = cfg_wpp ? (pw < 0 ? 0 : longint'(pw)) : 0;
         push_sample(px, py, pz, w, 1'b0);
      end else if (cnt >= 4) begin
         if (idx >= 3 && ((idx - 3) % stp) == 0) begin
            kmax = (!cfg_periodic && last) ? s : s - 1;
            sample_segment(win_pts, s, kmax);
         end
         // Closing segments of a periodic curve borrow the saved head points.
         if (cfg_periodic && last) begin
            for (int st = cnt - 3; st < cnt; st++) begin
               if (st % stp) continue;
               for (int j = 0; j < 4; j++) begin
                  m = st + j;
                  for (int f = 0; f < 4; f++)
                     wrap[j*4+f] = (m < cnt) ? win_pts[(m-(cnt-4))*4+f]
                                             : head_pts[(m-cnt)*4+f];
               end
               sample_segment(wrap, s, s - 1);
            end
         end
      end
      pos_in_curve = last ? 0 : idx + 1;
      if (step_samples.size() > 0) begin
         step_samples[$].rl = 1'b1;
         if (last) step_samples[$].ce = 1'b1;
      end
      expected_samples = {expected_samples, step_samples};
      return 1;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_set(input logic [1:0] idx, input logic [4:0] val);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         cct_pkg::CSR_BASIS:    cfg_basis = cct_pkg::basis_type'(val[1:0]);
         cct_pkg::CSR_PERIODIC: cfg_periodic = val[0];
         cct_pkg::CSR_SAMPLES:  cfg_samples = val;
         default:               cfg_wpp = val[0];
      endcase
   endtask

   task automatic set_config(input cct_pkg::basis_type b, input logic per,
                             input logic [4:0] s, input logic wpp);
      csr_set(cct_pkg::CSR_BASIS, 5'(b));
      csr_set(cct_pkg::CSR_PERIODIC, 5'(per));
      csr_set(cct_pkg::CSR_SAMPLES, s);
      csr_set(cct_pkg::CSR_WIDTH, 5'(wpp));
   endtask

   // Sends one point; the sender may idle for a random gap between bursts of random length.
   task automatic send_point(input logic signed [31:0] px, py, pz, pw,
                             input logic [15:0] vcount, input logic bstart);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz; req_point_width <= pw;
      req_curve_vertices <= vcount;
      req_batch_start <= bstart;
      do @(posedge clock); while (!req_ready);
      if (tessellate_point(px, py, pz, pw, vcount, bstart)) taken_points++;
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
      endcase
   endfunction

   task automatic send_curve(input int n, input logic [15:0] vcount, input logic bstart);
      for (int q = 0; q < n; q++)
         send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    (q == 0) ? vcount : 16'($urandom), (q == 0) ? bstart : 1'b0);
   endtask

   task automatic test_bspline_default();
      set_config(cct_pkg::BASIS_BSPLINE, 1'b0, 5'd1, 1'b0);
      send_curve(5, 16'd5, 1'b1);
   endtask

   task automatic test_linear();
      set_config(cct_pkg::BASIS_LINEAR, 1'b0, 5'd3, 1'b1);
      send_point(32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd5, 16'd3, 1'b0);
      send_point(32'sh80000000, 32'sh7fffffff, -32'sd1, 32'sh7fffffff, 16'hffff, 1'b0);
      send_point(32'sd1, 32'sd2, 32'sd3, 32'sh80000000, 16'd0, 1'b0);
   endtask

   task automatic test_catmull_extremes();
      set_config(cct_pkg::BASIS_CATMULL, 1'b0, 5'd16, 1'b1);
      send_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 16'd4, 1'b0);
      send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 16'd0, 1'b0);
      send_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 16'd0, 1'b0);
      send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 16'd0, 1'b0);
   endtask

   task automatic test_bezier_periodic();
      set_config(cct_pkg::BASIS_BEZIER, 1'b1, 5'd0, 1'b1);
      send_curve(6, 16'd6, 1'b0);
      csr_set(cct_pkg::CSR_SAMPLES, 5'd31);
      send_curve(3, 16'd3, 1'b0);
   endtask

   // Invalid counts latch an error; points are dropped until a batch start.
   task automatic test_error_latch();
      set_config(cct_pkg::BASIS_BEZIER, 1'b0, 5'd2, 1'b0);
      send_curve(1, 16'd5, 1'b0);
      send_curve(2, 16'd7, 1'b0);
      send_curve(4, 16'd4, 1'b1);
      csr_set(cct_pkg::CSR_BASIS, 5'(cct_pkg::BASIS_LINEAR));
      send_curve(1, 16'd0, 1'b0);
      send_curve(1, 16'd2, 1'b1);
   endtask

   task automatic test_random();
      cct_pkg::basis_type b;
      logic per;
      logic [4:0] s;
      int stp, n, phase = 0;
      while (taken_points < 460) begin
         if (phase % 4 == 0) begin
            b = cct_pkg::basis_type'($urandom_range(0, 3));
            per = 1'($urandom_range(0, 1));
            s = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(1, 4));
            set_config(b, per, s, 1'($urandom_range(0, 1)));
         end
         phase++;
         if (phase == 9) wait_drained();
         stp = (b == cct_pkg::BASIS_BEZIER) ? 3 : 1;
         case ($urandom_range(0, 9))
            0: begin
               // Short or huge count: an error beat and dropped points where the basis rejects it, then recovery.
               send_curve(1, 16'($urandom_range(0, 3) | ($urandom_range(0, 1) << 15)),
                          1'($urandom_range(0, 1)));
               send_curve($urandom_range(0, 3), 16'($urandom), 1'b0);
               n = per ? stp * $urandom_range(2, 4) : 4 + stp * $urandom_range(0, 2);
               send_curve(n, 16'(n), 1'b1);
            end
            1: begin
               // Curve cut short by a batch start.
               send_curve($urandom_range(1, 5), 16'd9, 1'b0);
               n = per ? stp * $urandom_range(2, 3) : 4 + stp;
               send_curve(n, 16'(n), 1'b1);
            end
            default: begin
               if (b == cct_pkg::BASIS_LINEAR) n = $urandom_range(1, 6);
               else if (per) n = stp * $urandom_range((stp == 3) ? 2 : 4, (stp == 3) ? 4 : 9);
               else n = 4 + stp * $urandom_range(0, (stp == 3) ? 2 : 6);
               send_curve(n, 16'(n), $urandom_range(0, 7) == 0);
            end
         endcase
      end
   endtask

   initial begin
      for (int q = 0; q < 16; q++) win_pts[q] = '0;
      for (int q = 0; q < 12; q++) head_pts[q] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bspline_default();
      test_linear();
      test_catmull_extremes();
      test_bezier_periodic();
      test_error_latch();
      test_random();
      wait_drained();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
